// File: design/cnfsa_pkg.sv
// Package for the circular next-free-slot allocator.
// Holds sizes, codes, the controller state type and the bit-search functions.
// No dependencies.
`default_nettype none

package cnfsa_pkg;

  localparam int NUM_SLOTS  = 1024;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int SLOT_W     = 10;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_LEAVE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_INIT   = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FREE   = 4'b1000
  } state_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] idx;
  } word_hit_t;

  // lowest set bit of a bitmap word
  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_IDX_W'(i);
    end
    return idx;
  endfunction

  // lowest flagged word in a summary vector
  function automatic word_hit_t first_word(input logic [NUM_WORDS-1:0] v);
    word_hit_t h;
    h.found = |v;
    h.idx   = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (v[i]) h.idx = WORD_IDX_W'(i);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: design/cnfsa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module cnfsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/circular_next_free_slot_allocator.sv
// Circular next-free-slot allocator, top level.
// Uses cnfsa_pkg and one cnfsa_ram instance holding the free bitmap.
`default_nettype none

// The block hands out slots 0 .. min(slot_count, 1024)-1; all are free after
// reset. An arrive word (in_tuser = 0) names a preferred slot and gets back the
// first free slot at or after it, wrapping to the lowest free slot, with status
// 0; status 1 means no slot is free, status 2 means the preferred slot is not
// below the count. A leave word (in_tuser = 1) frees its slot and gives no
// result; freeing a free slot or an out-of-range slot is harmless. The bitmap
// is 16 words of 64 bits in a RAM with a registered read; a 16-bit summary of
// non-empty words in flip-flops picks which word to read next. After reset a
// sweep writes all ones into the 16 bitmap words, one per cycle, so no request
// word is taken until the sweep is done. One word is in flight at a time. A
// leave reads its slot's word, then writes it back. An arrive first issues the
// read of the preferred slot's word, then examines one word at a time, at most
// three (the preferred word, the next word with a free bit above it, the first
// word with a free bit after wrapping). An out-of-range arrive is answered from
// the idle state with no RAM read. A result waits in an output register; a new
// word is taken once that register is empty or being drained.
// Configuration writes are taken at any time and should only come while idle.
module circular_next_free_slot_allocator
  import cnfsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration: slot_count
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [COUNT_W-1:0]    cfg_data,     // slot_count
  // request stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,     // [9:0] slot, zero above
  input  wire logic                  in_tuser,     // [0] operation
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,    // [9:0] assigned_slot, zero above
  output logic      [STATUS_W-1:0]   out_tuser     // [1:0] status
);

  // control registers
  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     slot_count_r, slot_count_nxt;
  logic [NUM_WORDS-1:0]   flags_r, flags_nxt;      // word has a free bit
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_IDX_W-1:0]  init_w_r, init_w_nxt;    // word written by the reset sweep
  // per-request context (no reset needed)
  logic [WORD_IDX_W-1:0]  w_lo_r, w_lo_nxt;        // preferred slot's word
  logic [BIT_IDX_W-1:0]   s_bit_r, s_bit_nxt;      // preferred slot's bit
  logic [WORD_IDX_W-1:0]  w_hi_r, w_hi_nxt;        // word of last slot in range
  logic [BIT_IDX_W-1:0]   top_r, top_nxt;          // bit of last slot in range
  logic [WORD_IDX_W-1:0]  cur_w_r, cur_w_nxt;      // word whose data is on rd_data
  logic                   wrap_r, wrap_nxt;        // searching below the preferred slot
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;

  // RAM port
  logic                   ram_we, ram_re;
  logic [WORD_IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]   ram_wdata, rd_data;

  cnfsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // effective count, saturated to the slot total
  logic [COUNT_W-1:0] eff_count, last_slot;
  logic [SLOT_W-1:0]  in_slot;
  logic               in_range, out_free, in_fire;

  assign eff_count = (slot_count_r > COUNT_W'(NUM_SLOTS)) ? COUNT_W'(NUM_SLOTS)
                                                          : slot_count_r;
  assign last_slot = eff_count - COUNT_W'(1);
  assign in_slot   = in_tdata[SLOT_W-1:0];
  assign in_range  = {1'b0, in_slot} < eff_count;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_slot_r);
  assign out_tuser  = out_status_r;

  // search over the word now on rd_data
  logic [WORD_BITS-1:0]  word_mask, cand, taken_word;
  logic                  hit;
  logic [BIT_IDX_W-1:0]  hit_bit;
  logic [WORD_IDX_W-1:0] bound;
  logic [NUM_WORDS-1:0]  range_a, range_b;
  word_hit_t             next_a, next_b;

  always_comb begin
    word_mask = '1;
    if (cur_w_r == w_lo_r) begin
      if (wrap_r) begin
        word_mask = word_mask & ~({WORD_BITS{1'b1}} << s_bit_r);
      end else begin
        word_mask = word_mask & ({WORD_BITS{1'b1}} << s_bit_r);
      end
    end
    if (cur_w_r == w_hi_r) begin
      word_mask = word_mask & ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - top_r));
    end
    cand       = rd_data & word_mask;
    hit        = |cand;
    hit_bit    = lowest_bit(cand);
    taken_word = rd_data & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << hit_bit);

    // next candidate word in this pass: (cur, bound]
    bound   = wrap_r ? w_lo_r : w_hi_r;
    range_a = ({NUM_WORDS{1'b1}} << ({1'b0, cur_w_r} + (WORD_IDX_W+1)'(1)))
            & ({NUM_WORDS{1'b1}} >> (WORD_IDX_W'(NUM_WORDS - 1) - bound));
    next_a  = first_word(flags_r & range_a);
    // first word of the wrapped pass: [0, w_lo]
    range_b = {NUM_WORDS{1'b1}} >> (WORD_IDX_W'(NUM_WORDS - 1) - w_lo_r);
    next_b  = first_word(flags_r & range_b);
  end

  always_comb begin
    state_nxt      = state_r;
    slot_count_nxt = slot_count_r;
    flags_nxt      = flags_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    init_w_nxt     = init_w_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    w_lo_nxt       = w_lo_r;
    s_bit_nxt      = s_bit_r;
    w_hi_nxt       = w_hi_r;
    top_nxt        = top_r;
    cur_w_nxt      = cur_w_r;
    wrap_nxt       = wrap_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_w_r;
    ram_wdata      = taken_word;
    ram_re         = 1'b0;
    ram_raddr      = in_slot[SLOT_W-1:BIT_IDX_W];

    if (cfg_valid && cfg_ready) begin
      slot_count_nxt = cfg_data;
    end

    case (state_r)
      S_INIT: begin
        // fill one bitmap word with ones per cycle, then open the input
        ram_we     = 1'b1;
        ram_waddr  = init_w_r;
        ram_wdata  = '1;
        init_w_nxt = init_w_r + WORD_IDX_W'(1);
        if (init_w_r == WORD_IDX_W'(NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          w_lo_nxt  = in_slot[SLOT_W-1:BIT_IDX_W];
          s_bit_nxt = in_slot[BIT_IDX_W-1:0];
          w_hi_nxt  = last_slot[SLOT_W-1:BIT_IDX_W];
          top_nxt   = last_slot[BIT_IDX_W-1:0];
          cur_w_nxt = in_slot[SLOT_W-1:BIT_IDX_W];
          wrap_nxt  = 1'b0;
          if (in_tuser == OP_LEAVE) begin
            // drop a leave outside the range
            if (in_range) begin
              ram_re    = 1'b1;
              state_nxt = S_FREE;
            end
          end else if (!in_range) begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = '0;
            out_status_nxt = ST_RANGE;
          end else begin
            ram_re    = 1'b1;
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          // take the slot once the result register can hold it
          if (out_free) begin
            ram_we             = 1'b1;
            flags_nxt[cur_w_r] = |taken_word;
            out_valid_nxt      = 1'b1;
            out_slot_nxt       = {cur_w_r, hit_bit};
            out_status_nxt     = ST_OK;
            state_nxt          = S_IDLE;
          end
        end else if (next_a.found) begin
          ram_re    = 1'b1;
          ram_raddr = next_a.idx;
          cur_w_nxt = next_a.idx;
        end else if (!wrap_r && next_b.found) begin
          ram_re    = 1'b1;
          ram_raddr = next_b.idx;
          cur_w_nxt = next_b.idx;
          wrap_nxt  = 1'b1;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = '0;
          out_status_nxt = ST_FULL;
          state_nxt      = S_IDLE;
        end
      end

      S_FREE: begin
        ram_we            = 1'b1;
        ram_waddr         = w_lo_r;
        ram_wdata         = rd_data | ({{(WORD_BITS-1){1'b0}}, 1'b1} << s_bit_r);
        flags_nxt[w_lo_r] = 1'b1;
        state_nxt         = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      slot_count_r <= COUNT_RESET;
      flags_r      <= '1;
      out_valid_r  <= 1'b0;
      init_w_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      flags_r      <= flags_nxt;
      out_valid_r  <= out_valid_nxt;
      init_w_r     <= init_w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    w_lo_r       <= w_lo_nxt;
    s_bit_r      <= s_bit_nxt;
    w_hi_r       <= w_hi_nxt;
    top_r        <= top_nxt;
    cur_w_r      <= cur_w_nxt;
    wrap_r       <= wrap_nxt;
  end

  // The bitmap RAM itself has no reset; the S_INIT sweep above fills it with
  // ones before the first request is taken.
endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for circular_next_free_slot_allocator: directed script, then random phases.
// Checks every result word against an in-bench bitmap predictor or a scripted expectation.
// Depends on cnfsa_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb;
  import cnfsa_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 12;
  // give a trailing leave or arrive a margin to finish
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SCRIPT_LEN     = 25;
  localparam int PHASES         = 11;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } grant_t;

  // one line of the directed script: either a slot_count write or a request word
  typedef struct packed {
    logic                is_cfg;
    logic                op;
    logic [COUNT_W-1:0]  value;
    logic                typed;
    grant_t              want;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // allocator shadow: bit set when the slot is free, plus the slot_count register
  logic [NUM_SLOTS-1:0]  free_map;
  logic [COUNT_W-1:0]    slot_limit;
  grant_t                grants_due[$];
  grant_t                due;

  int  errors;
  int  idle_cycles;
  int  rx_hold;
  int  rx_gap;
  bit  tx_quiet;
  bit  rx_quiet;

  circular_next_free_slot_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [9:0] slot, zero above
    .in_tuser   (in_tuser),     // [0] operation
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [9:0] assigned_slot, zero above
    .out_tuser  (out_tuser)     // [1:0] status
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Idle length: mostly none, often a short gap, now and then a long stretch.
  function automatic int idle_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // slot_count saturates at the bitmap size
  function automatic int unsigned live_slots();
    return (slot_limit > NUM_SLOTS) ? NUM_SLOTS : slot_limit;
  endfunction

  // Search from the preferred slot upward, wrap to the bottom, and claim the hit.
  // Out-of-range and full answers leave the bitmap untouched.
  function automatic grant_t take_slot(input logic [SLOT_W-1:0] pref);
    grant_t      g;
    int unsigned eff;
    int unsigned idx;
    bit          hit;
    eff = live_slots();
    g   = '0;
    hit = 1'b0;
    if (pref >= eff) begin
      g.status = ST_RANGE;
      return g;
    end
    for (int unsigned i = 0; i < eff && !hit; i++) begin
      idx = pref + i;
      if (idx >= eff) idx -= eff;
      if (free_map[idx]) begin
        hit    = 1'b1;
        g.slot = idx[SLOT_W-1:0];
      end
    end
    if (hit) begin
      free_map[g.slot] = 1'b0;
      g.status         = ST_OK;
    end else begin
      g.status = ST_FULL;
    end
    return g;
  endfunction

  function automatic script_row_t req(input logic op, input int unsigned slot);
    req       = '0;
    req.op    = op;
    req.value = COUNT_W'(slot);
  endfunction

  // arrive whose answer is plain from the current bitmap
  function automatic script_row_t req_exp(input int unsigned slot, input int unsigned got,
                                          input logic [STATUS_W-1:0] st);
    req_exp             = req(OP_ARRIVE, slot);
    req_exp.typed       = 1'b1;
    req_exp.want.slot   = SLOT_W'(got);
    req_exp.want.status = st;
  endfunction

  function automatic script_row_t set_count(input int unsigned v);
    set_count        = '0;
    set_count.is_cfg = 1'b1;
    set_count.value  = COUNT_W'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Drive one request word after an optional gap and hold it until accepted.
  // Update the shadow bitmap at the accepting edge so order matches the block.
  task automatic push_request(input logic op, input logic [SLOT_W-1:0] slot, input int gap,
                              input logic typed, input grant_t typed_grant);
    grant_t g;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(slot);
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (op == OP_LEAVE) begin
      // a leave outside the count is ignored, freeing a free slot is harmless
      if (slot < live_slots()) free_map[slot] = 1'b1;
    end else begin
      g = take_slot(slot);
      grants_due.push_back(typed ? typed_grant : g);
    end
  endtask

  // Drop valid, wait for every pending grant, then let a trailing leave finish.
  task automatic settle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // slot_count is only written with the block drained
  task automatic write_count(input logic [COUNT_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    slot_limit = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Result side back-pressure: hold ready low for a random stall, then reopen.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      rx_gap      = idle_gap(rx_quiet);
      out_tready <= (rx_gap == 0);
      rx_hold    <= (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  // Compare each accepted result word with the oldest pending grant.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (grants_due.size() == 0) begin
        report_mismatch($sformatf("result slot %0d status %0d with no arrive pending",
                                  out_tdata, out_tuser));
      end else begin
        due = grants_due.pop_front();
        if (out_tdata != OUT_DATA_W'(due.slot))
          report_mismatch($sformatf("assigned_slot %0d, want %0d", out_tdata, due.slot));
        if (out_tuser != due.status)
          report_mismatch($sformatf("status %0d, want %0d", out_tuser, due.status));
      end
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("circular_next_free_slot_allocator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    script_row_t                script [SCRIPT_LEN];
    logic [COUNT_W-1:0]         limits [PHASES];
    int                         items;
    int                         arrive_pct;
    int unsigned                eff;
    logic                       op;
    logic [SLOT_W-1:0]          slot;

    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    free_map   = '1;
    slot_limit = COUNT_RESET;
    errors     = 0;
    tx_quiet   = 1'b1;
    rx_quiet   = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part, starting from the reset count of 1024 with every slot free.
    script = '{
      req_exp(0, 0, ST_OK),            // lowest slot right after reset
      req_exp(1023, 1023, ST_OK),      // highest slot right after reset
      req(OP_ARRIVE, 1023),            // top taken: wrap to the bottom
      req(OP_LEAVE, 0),
      req(OP_LEAVE, 0),                // free the same slot twice
      req(OP_ARRIVE, 1023),            // wrap again onto the freed slot
      req(OP_ARRIVE, 63),              // last bit of a bitmap word
      req(OP_ARRIVE, 64),              // first bit of the next word
      req(OP_LEAVE, 700),              // free a slot never taken
      req(OP_ARRIVE, 62),
      set_count(1),                    // smallest nonzero count, its only slot taken
      req_exp(0, 0, ST_FULL),
      req_exp(1, 0, ST_RANGE),
      req(OP_LEAVE, 1023),             // leave above the count: ignored
      req(OP_LEAVE, 0),
      req_exp(0, 0, ST_OK),
      set_count(0),                    // zero count: every arrive is out of range
      req_exp(0, 0, ST_RANGE),
      req(OP_LEAVE, 1),
      req_exp(1023, 0, ST_RANGE),
      set_count(2047),                 // above the bitmap size: saturate
      req(OP_ARRIVE, 1023),
      req(OP_ARRIVE, 512),
      req(OP_LEAVE, 1023),
      req_exp(1023, 1023, ST_OK)       // a freed slot is handed straight back
    };
    foreach (script[i]) begin
      if (script[i].is_cfg) write_count(script[i].value);
      else push_request(script[i].op, script[i].value[SLOT_W-1:0], 0,
                        script[i].typed, script[i].want);
    end

    // Random phases. Small counts fill up fast and hit the full answer often;
    // the bitmap carries over between phases, so a larger count later
    // exposes any slot a leave outside the count wrongly freed.
    limits = '{11'd1024, 11'd64, 11'd65, 11'd1, 11'd2, 11'd130, 11'd2047,
               11'd0, 11'd17, 11'd700, 11'd1024};
    limits[PHASES-1] = COUNT_W'($urandom_range(3, 1024));
    foreach (limits[p]) begin
      write_count(limits[p]);
      tx_quiet   = ($urandom_range(0, 3) == 0);
      rx_quiet   = ($urandom_range(0, 3) == 0);
      arrive_pct = $urandom_range(45, 75);
      items      = (limits[p] == 0) ? 25 : 172;
      for (int n = 0; n < items; n++) begin
        // hold off now and then until every grant is back
        if ($urandom_range(0, 99) == 0) settle();
        eff  = live_slots();
        op   = ($urandom_range(0, 99) < arrive_pct) ? OP_ARRIVE : OP_LEAVE;
        // mostly slots inside the count, the rest anywhere in the field
        if (eff > 0 && $urandom_range(0, 9) != 0) slot = SLOT_W'($urandom_range(0, eff - 1));
        else slot = SLOT_W'($urandom_range(0, 1023));
        push_request(op, slot, idle_gap(tx_quiet), 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("circular_next_free_slot_allocator test passed");
    end else begin
      $display("circular_next_free_slot_allocator test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/cnfsa_pkg.sv
design/cnfsa_ram.sv
design/circular_next_free_slot_allocator.sv
test/tb.sv
